// ===== rtl/core/smp_pkg.sv =====
// Shared types and constants for the semiring matrix power block.
// Used by every file under rtl/core but smp_ram; depends on nothing.
package smp_pkg;

	localparam int MAX_DIM_DEF    = 8;
	localparam int VALUE_BITS_DEF = 56;
	localparam int ENTRY_BITS     = 55;
	localparam int EXP_BITS       = 63;
	localparam int ADDR_BITS      = 6;
	localparam int CFG_IDX_BITS   = 2;
	localparam int CFG_DATA_BITS  = 4;
	localparam int MODE_BITS      = 2;
	localparam int SIZE_BITS      = 4;
	localparam int ACC_BITS       = 64;
	localparam int RES_BITS       = 30;

	localparam logic [SIZE_BITS-1:0] SIZE_RESET = 4'd8;
	localparam logic [RES_BITS-1:0] MODULUS = 30'd1000000007;
	localparam logic signed [63:0] INF_VAL = 64'sd10000000000000042;

	localparam logic [CFG_IDX_BITS-1:0] CFG_MODE = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SIZE = 2'd1;

	typedef enum logic [MODE_BITS-1:0] {
		SR_MOD = 2'd0,
		SR_MIN = 2'd1,
		SR_MAX = 2'd2
	} sr_mode_t;

	typedef struct packed {
		logic                 issue;
		logic                 first;
		logic                 last;
		logic                 norm;
		logic                 a_base;
		logic                 bank;
		sr_mode_t             mode;
		logic [ADDR_BITS-1:0] raddr_a;
		logic [ADDR_BITS-1:0] raddr_b;
		logic [ADDR_BITS-1:0] waddr;
		logic                 load_we;
		logic [ADDR_BITS-1:0] load_addr;
		logic                 out_load;
		logic                 out_last;
	} smp_cmd_t;

	typedef struct packed {
		logic done;
		logic out_free;
	} smp_sts_t;

endpackage

// ===== rtl/core/smp_entry_if.sv =====
// Input channel of the semiring matrix power block: one matrix entry per transfer.
// Depends on smp_pkg for field widths.
interface smp_entry_if;
	logic                                      valid;
	logic                                      ready;
	logic signed [smp_pkg::ENTRY_BITS-1:0]     entry_value;
	logic [smp_pkg::EXP_BITS-1:0]              exponent;

	modport source(output valid, entry_value, exponent, input ready);
	modport sink(input valid, entry_value, exponent, output ready);
endinterface

// ===== rtl/core/smp_result_if.sv =====
// Output channel of the semiring matrix power block: one result entry per transfer.
// Depends on smp_pkg for field widths.
interface smp_result_if;
	logic                                      valid;
	logic                                      ready;
	logic signed [smp_pkg::ENTRY_BITS-1:0]     result_value;
	logic                                      last_entry;

	modport source(output valid, result_value, last_entry, input ready);
	modport sink(input valid, result_value, last_entry, output ready);
endinterface

// ===== rtl/core/semiring_matrix_power.sv =====
// Matrix power by square-and-multiply in the modular, min-plus or max-plus semiring.
// Depends on smp_pkg, smp_entry_if, smp_result_if, smp_ctrl and smp_datapath.
//
// Entries of an n x n matrix are taken one per cycle in row-major order; the transfer of
// the last entry also carries the exponent and starts the job. The loaded matrix is first
// normalised entry by entry, then the exponent is scanned one bit a cycle from the top
// while no product is in progress; every bit after the leading one costs a squaring and,
// when set, a multiply by the loaded matrix. A product takes n*n entries, each of n
// multiply-accumulate steps followed by a pipeline drain and, in modular mode, a
// reduction. The n*n results then leave one at a time, each read from the store and
// then loaded into the output register, the last one flagged.
// Entries are taken again once the final result sits in the output register.
module semiring_matrix_power #(
	parameter int MAX_DIM    = smp_pkg::MAX_DIM_DEF,
	parameter int VALUE_BITS = smp_pkg::VALUE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [smp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [smp_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
	smp_entry_if.sink                         entries,
	smp_result_if.source                      results
);
	import smp_pkg::*;

	smp_cmd_t cmd;
	smp_sts_t sts;

	smp_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(entries.valid), .in_ready(entries.ready), .exponent(entries.exponent),
		.cmd(cmd), .sts(sts)
	);

	smp_datapath #(.MAX_DIM(MAX_DIM), .VALUE_BITS(VALUE_BITS)) u_datapath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.entry_value(entries.entry_value),
		.out_valid(results.valid), .out_ready(results.ready),
		.result_value(results.result_value), .last_entry(results.last_entry)
	);

endmodule

// ===== rtl/core/smp_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module smp_ram #(
	parameter int WIDTH = 56,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== rtl/core/smp_modred.sv =====
// Reduction of a 64-bit magnitude modulo 1e9+7 by reciprocal multiplication in registered stages.
// Depends on smp_pkg.
module smp_modred (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [smp_pkg::ACC_BITS-1:0]   value,
	input  logic                           neg,
	output logic                           busy,
	output logic                           done,
	output logic [smp_pkg::RES_BITS-1:0]   result
);
	import smp_pkg::*;

	localparam int HI_BITS = 32;
	localparam int QW      = 35;
	localparam int RW      = 34;
	localparam int FIX_MAX = 6;
	localparam logic [QW-1:0] RECIP = 35'd18446743944;

	logic                      vld_s1, vld_s2, vld_s3, done_q;
	logic [ACC_BITS-1:0]       v_s1;
	logic                      neg_s1, neg_s2, neg_s3;
	logic [QW-1:0]             q_s2;
	logic [RW-1:0]             low_s2;
	logic [RW-1:0]             r_s3;
	logic [RES_BITS-1:0]       res_q;
	logic [HI_BITS+QW-1:0]     q_full;
	logic [RW-1:0]             qp;
	logic [RW-1:0]             sub;
	logic [RES_BITS-1:0]       r_fix;

	// quotient estimate falls short of the true quotient by at most six
	assign q_full = (HI_BITS+QW)'(v_s1[ACC_BITS-1:ACC_BITS-HI_BITS]) * (HI_BITS+QW)'(RECIP);
	assign qp     = RW'(q_s2) * RW'(MODULUS);

	always_comb begin
		sub = '0;
		for (int k = 1; k <= FIX_MAX; k++) begin
			if (r_s3 >= RW'(k) * RW'(MODULUS)) begin
				sub = RW'(k) * RW'(MODULUS);
			end
		end
		r_fix = RES_BITS'(r_s3 - sub);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			done_q <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_s1   <= value;
			neg_s1 <= neg;
		end
		if (vld_s1) begin
			q_s2   <= q_full[HI_BITS+QW-1:HI_BITS];
			low_s2 <= v_s1[RW-1:0];
			neg_s2 <= neg_s1;
		end
		if (vld_s2) begin
			r_s3   <= low_s2 - qp;
			neg_s3 <= neg_s2;
		end
		if (vld_s3) begin
			res_q <= (neg_s3 && (r_fix != '0)) ? MODULUS - r_fix : r_fix;
		end
	end

	assign busy   = vld_s1 || vld_s2 || vld_s3;
	assign done   = done_q;
	assign result = res_q;

endmodule

// ===== rtl/core/smp_datapath.sv =====
// Datapath: matrix stores, multiply-accumulate pipeline, reduction unit and output register.
// Depends on smp_pkg, smp_ram and smp_modred.
module smp_datapath #(
	parameter int MAX_DIM    = smp_pkg::MAX_DIM_DEF,
	parameter int VALUE_BITS = smp_pkg::VALUE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  smp_pkg::smp_cmd_t                     cmd,
	output smp_pkg::smp_sts_t                     sts,
	input  logic signed [smp_pkg::ENTRY_BITS-1:0] entry_value,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [smp_pkg::ENTRY_BITS-1:0] result_value,
	output logic                                  last_entry
);
	import smp_pkg::*;

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic signed [VALUE_BITS-1:0] POS_INF = VALUE_BITS'(INF_VAL);
	localparam logic signed [VALUE_BITS-1:0] NEG_INF = -POS_INF;

	typedef struct packed {
		logic                 valid;
		logic                 first;
		logic                 last;
		logic                 norm;
		logic                 a_base;
		logic                 bank;
		logic [ADDR_BITS-1:0] waddr;
	} pipe_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] waddr;
		logic                 norm;
		logic                 bank;
	} wb_t;

	pipe_t ctl_s1, ctl_s2, ctl_s3;
	wb_t   wb_q;

	logic [VALUE_BITS-1:0] base_rd_a, acc0_rd_a, acc0_rd_b, acc1_rd_a, acc1_rd_b;
	logic                  base_we, acc0_we, acc1_we;
	logic [ADDR_BITS-1:0]  base_waddr;
	logic [VALUE_BITS-1:0] base_wdata;

	logic signed [VALUE_BITS-1:0] x, y, tsel;
	logic signed [VALUE_BITS:0]   tsum;
	logic [2*RES_BITS-1:0]        prod;
	logic [ACC_BITS-1:0]          term_next, term_s2, acc_s3, comb_val;
	logic signed [ACC_BITS-1:0]   acc_sv;
	logic [VALUE_BITS-1:0]        clamp_val;
	logic [VALUE_BITS-1:0]        out_rd;

	logic                  fin, is_mod, red_start, red_neg, red_busy, red_done;
	logic [ACC_BITS-1:0]   red_value;
	logic [RES_BITS-1:0]   red_result;

	logic                  wr_en, wr_norm, wr_bank;
	logic [ADDR_BITS-1:0]  wr_addr;
	logic [VALUE_BITS-1:0] wr_val;

	logic out_valid_q;

	smp_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_base (
		.clk(clk), .we(base_we), .waddr(AW'(base_waddr)), .wdata(base_wdata),
		.raddr_a(AW'(cmd.raddr_a)), .raddr_b(AW'(cmd.raddr_b)),
		.rdata_a(base_rd_a), .rdata_b()
	);

	smp_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_acc0 (
		.clk(clk), .we(acc0_we), .waddr(AW'(wr_addr)), .wdata(wr_val),
		.raddr_a(AW'(cmd.raddr_a)), .raddr_b(AW'(cmd.raddr_b)),
		.rdata_a(acc0_rd_a), .rdata_b(acc0_rd_b)
	);

	smp_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_acc1 (
		.clk(clk), .we(acc1_we), .waddr(AW'(wr_addr)), .wdata(wr_val),
		.raddr_a(AW'(cmd.raddr_a)), .raddr_b(AW'(cmd.raddr_b)),
		.rdata_a(acc1_rd_a), .rdata_b(acc1_rd_b)
	);

	smp_modred u_modred (
		.clk(clk), .arst_n(arst_n), .start(red_start), .value(red_value), .neg(red_neg),
		.busy(red_busy), .done(red_done), .result(red_result)
	);

	// operand selection
	assign x = ctl_s1.a_base ? base_rd_a : (ctl_s1.bank ? acc1_rd_a : acc0_rd_a);
	assign y = ctl_s1.bank ? acc1_rd_b : acc0_rd_b;
	assign out_rd = cmd.bank ? acc1_rd_b : acc0_rd_b;

	assign tsum = (VALUE_BITS+1)'(x) + (VALUE_BITS+1)'(y);
	assign prod = x[RES_BITS-1:0] * y[RES_BITS-1:0];

	always_comb begin
		tsel = tsum[VALUE_BITS-1:0];
		if (cmd.mode == SR_MIN && (x >= POS_INF || y >= POS_INF)) begin
			tsel = POS_INF;
		end else if (cmd.mode == SR_MAX && (x <= NEG_INF || y <= NEG_INF)) begin
			tsel = NEG_INF;
		end else if (tsum > POS_INF) begin
			tsel = POS_INF;
		end else if (tsum < NEG_INF) begin
			tsel = NEG_INF;
		end
	end

	always_comb begin
		if (ctl_s1.norm) begin
			term_next = ACC_BITS'(x);
		end else if (cmd.mode == SR_MOD) begin
			term_next = ACC_BITS'(prod);
		end else begin
			term_next = ACC_BITS'(tsel);
		end
	end

	always_comb begin
		case (cmd.mode)
			SR_MIN: comb_val = ($signed(term_s2) < $signed(acc_s3)) ? term_s2 : acc_s3;
			SR_MAX: comb_val = ($signed(term_s2) > $signed(acc_s3)) ? term_s2 : acc_s3;
			default: comb_val = acc_s3 + term_s2;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1      <= '0;
			ctl_s2      <= '0;
			ctl_s3      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			ctl_s1 <= '{valid: cmd.issue, first: cmd.first, last: cmd.last, norm: cmd.norm,
				a_base: cmd.a_base, bank: cmd.bank, waddr: cmd.waddr};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		term_s2 <= term_next;
		if (ctl_s2.valid) begin
			acc_s3 <= ctl_s2.first ? term_s2 : comb_val;
		end
		if (red_start) begin
			wb_q <= '{waddr: ctl_s3.waddr, norm: ctl_s3.norm, bank: ctl_s3.bank};
		end
		if (cmd.out_load) begin
			result_value <= out_rd[ENTRY_BITS-1:0];
			last_entry   <= cmd.out_last;
		end
	end

	// finish: reduce in mod mode, write straight back otherwise
	assign fin       = ctl_s3.valid && ctl_s3.last;
	assign is_mod    = cmd.mode == SR_MOD;
	assign red_start = fin && is_mod;
	assign red_neg   = ctl_s3.norm && acc_s3[ACC_BITS-1];
	assign red_value = red_neg ? (~acc_s3 + 1'b1) : acc_s3;

	assign acc_sv = $signed(acc_s3);
	always_comb begin
		if (acc_sv > ACC_BITS'(POS_INF)) begin
			clamp_val = POS_INF;
		end else if (acc_sv < ACC_BITS'(NEG_INF)) begin
			clamp_val = NEG_INF;
		end else begin
			clamp_val = acc_s3[VALUE_BITS-1:0];
		end
	end

	assign wr_en   = (fin && !is_mod) || red_done;
	assign wr_addr = red_done ? wb_q.waddr : ctl_s3.waddr;
	assign wr_norm = red_done ? wb_q.norm : ctl_s3.norm;
	assign wr_bank = red_done ? wb_q.bank : ctl_s3.bank;
	assign wr_val  = red_done ? VALUE_BITS'(red_result)
		: (ctl_s3.norm ? clamp_val : acc_s3[VALUE_BITS-1:0]);

	assign base_we    = cmd.load_we || (wr_en && wr_norm);
	assign base_waddr = cmd.load_we ? cmd.load_addr : wr_addr;
	assign base_wdata = cmd.load_we ? VALUE_BITS'(entry_value) : wr_val;
	assign acc0_we    = wr_en && (wr_norm || wr_bank);
	assign acc1_we    = wr_en && !wr_norm && !wr_bank;

	assign sts.done     = wr_en;
	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;

	assert property (@(posedge clk) disable iff (!arst_n) red_start |-> !red_busy)
		else $error("reduction started while busy");
	assert property (@(posedge clk) disable iff (!arst_n) cmd.load_we |-> !wr_en)
		else $error("load write collides with result write");

endmodule

// ===== rtl/core/smp_ctrl.sv =====
// Controller: loading, normalise pass, square-and-multiply sequencing, result readout.
// Depends on smp_pkg.
module smp_ctrl #(
	parameter int MAX_DIM = smp_pkg::MAX_DIM_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [smp_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [smp_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [smp_pkg::EXP_BITS-1:0]        exponent,
	output smp_pkg::smp_cmd_t                   cmd,
	input  smp_pkg::smp_sts_t                   sts
);
	import smp_pkg::*;

	localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int LEFT_BITS = $clog2(EXP_BITS + 1);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_NORM,
		ST_BIT,
		ST_MAC,
		ST_WAIT,
		ST_OUT_RD,
		ST_OUT_LD
	} state_t;

	state_t                 state_q;
	logic [MODE_BITS-1:0]   mode_q;
	logic [SIZE_BITS-1:0]   size_q;
	logic [IW-1:0]          i_q, j_q, k_q, dm1;
	logic [EXP_BITS-1:0]    exp_q;
	logic [LEFT_BITS-1:0]   left_q;
	logic                   seen_q, pend_q, a_base_q, bank_q, norm_q;
	logic                   end_ij;
	sr_mode_t               mode_dec;

	function automatic logic [ADDR_BITS-1:0] cell_addr(input logic [IW-1:0] r,
		input logic [IW-1:0] c);
		return ADDR_BITS'(ADDR_BITS'(r) * ADDR_BITS'(MAX_DIM) + ADDR_BITS'(c));
	endfunction

	always_comb begin
		if (size_q == '0) begin
			dm1 = '0;
		end else if (size_q > SIZE_BITS'(MAX_DIM)) begin
			dm1 = IW'(MAX_DIM - 1);
		end else begin
			dm1 = IW'(size_q - 1'b1);
		end
	end

	always_comb begin
		unique case (mode_q)
			SR_MIN: mode_dec = SR_MIN;
			SR_MAX: mode_dec = SR_MAX;
			default: mode_dec = SR_MOD;
		endcase
	end

	assign end_ij = (i_q == dm1) && (j_q == dm1);
	assign in_ready = state_q == ST_LOAD;

	always_comb begin
		cmd = '0;
		cmd.mode = mode_dec;
		cmd.bank = bank_q;
		cmd.a_base = a_base_q;
		unique case (state_q)
			ST_LOAD: begin
				cmd.load_we = in_valid;
				cmd.load_addr = cell_addr(i_q, j_q);
			end
			ST_NORM: begin
				cmd.issue = 1'b1;
				cmd.first = 1'b1;
				cmd.last = 1'b1;
				cmd.norm = 1'b1;
				cmd.a_base = 1'b1;
				cmd.raddr_a = cell_addr(i_q, j_q);
				cmd.waddr = cell_addr(i_q, j_q);
			end
			ST_MAC: begin
				cmd.issue = 1'b1;
				cmd.first = k_q == '0;
				cmd.last = k_q == dm1;
				cmd.raddr_a = cell_addr(i_q, k_q);
				cmd.raddr_b = cell_addr(k_q, j_q);
				cmd.waddr = cell_addr(i_q, j_q);
			end
			ST_OUT_RD: begin
				cmd.raddr_b = cell_addr(i_q, j_q);
			end
			ST_OUT_LD: begin
				cmd.raddr_b = cell_addr(i_q, j_q);
				cmd.out_load = sts.out_free;
				cmd.out_last = end_ij;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			mode_q   <= '0;
			size_q   <= SIZE_RESET;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
			exp_q    <= '0;
			left_q   <= '0;
			seen_q   <= 1'b0;
			pend_q   <= 1'b0;
			a_base_q <= 1'b0;
			bank_q   <= 1'b0;
			norm_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_valid) begin
						if (end_ij) begin
							i_q     <= '0;
							j_q     <= '0;
							exp_q   <= exponent;
							left_q  <= LEFT_BITS'(EXP_BITS);
							seen_q  <= 1'b0;
							pend_q  <= 1'b0;
							bank_q  <= 1'b0;
							norm_q  <= 1'b1;
							state_q <= ST_NORM;
						end else if (j_q == dm1) begin
							j_q <= '0;
							i_q <= i_q + 1'b1;
						end else begin
							j_q <= j_q + 1'b1;
						end
					end
				end
				ST_NORM: begin
					state_q <= ST_WAIT;
				end
				ST_BIT: begin
					if (left_q == '0) begin
						state_q <= ST_OUT_RD;
					end else begin
						exp_q  <= {exp_q[EXP_BITS-2:0], 1'b0};
						left_q <= left_q - 1'b1;
						if (!seen_q) begin
							seen_q <= exp_q[EXP_BITS-1];
						end else begin
							pend_q   <= exp_q[EXP_BITS-1];
							a_base_q <= 1'b0;
							state_q  <= ST_MAC;
						end
					end
				end
				ST_MAC: begin
					if (k_q == dm1) begin
						k_q     <= '0;
						state_q <= ST_WAIT;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_WAIT: begin
					if (sts.done) begin
						if (end_ij) begin
							i_q <= '0;
							j_q <= '0;
							if (norm_q) begin
								norm_q  <= 1'b0;
								state_q <= ST_BIT;
							end else begin
								bank_q <= ~bank_q;
								if (pend_q) begin
									pend_q   <= 1'b0;
									a_base_q <= 1'b1;
									state_q  <= ST_MAC;
								end else begin
									state_q <= ST_BIT;
								end
							end
						end else begin
							if (j_q == dm1) begin
								j_q <= '0;
								i_q <= i_q + 1'b1;
							end else begin
								j_q <= j_q + 1'b1;
							end
							state_q <= norm_q ? ST_NORM : ST_MAC;
						end
					end
				end
				ST_OUT_RD: begin
					state_q <= ST_OUT_LD;
				end
				ST_OUT_LD: begin
					if (sts.out_free) begin
						if (end_ij) begin
							i_q     <= '0;
							j_q     <= '0;
							state_q <= ST_LOAD;
						end else begin
							if (j_q == dm1) begin
								j_q <= '0;
								i_q <= i_q + 1'b1;
							end else begin
								j_q <= j_q + 1'b1;
							end
							state_q <= ST_OUT_RD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase

			if (cfg_we) begin
				unique case (cfg_index)
					CFG_MODE: mode_q <= cfg_wdata[MODE_BITS-1:0];
					CFG_SIZE: begin
						size_q <= cfg_wdata[SIZE_BITS-1:0];
						i_q    <= '0;
						j_q    <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) sts.done |-> state_q == ST_WAIT)
		else $error("result write outside wait state");
	assert property (@(posedge clk) disable iff (!arst_n)
		(i_q <= dm1) && (j_q <= dm1) && (k_q <= dm1))
		else $error("index beyond matrix size");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BIT) && (left_q == '0) |=> state_q == ST_OUT_RD)
		else $error("exponent scan did not end in readout");

endmodule
